// ===== rtl/rotation_matrix_logarithm_top_macros.svh =====
// Assertion macros shared by the rotation matrix logarithm RTL
`ifndef ROTATION_MATRIX_LOGARITHM_TOP_MACROS_SVH
`define ROTATION_MATRIX_LOGARITHM_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define RML_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rml assertion failed");

// next-cycle implication, disabled in reset
`define RML_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rml assertion failed");

`endif

// ===== rtl/rml_pkg.sv =====
// Types, widths and constants of the rotation matrix logarithm pipeline
`default_nettype none
package rml_pkg;

   localparam int MAT_W         = 16;
   localparam int P_W           = 18;
   localparam int SQ_W          = 34;
   localparam int SUMSQ_W       = 36;
   localparam int ROOT_W        = 31;
   localparam int REM_W         = 35;
   localparam int SQ_STAGES     = 31;
   localparam int CORDIC_STAGES = 20;
   localparam int CX_W          = 46;
   localparam int CZ_W          = 22;
   localparam int ZC_W          = 21;
   localparam int MAG_W         = 17;
   localparam int PROD_W        = 38;
   localparam int DIVD_W        = 47;
   localparam int DIVS_W        = 32;
   localparam int REMD_W        = 48;
   localparam int QUO_W         = 16;
   localparam int DIV_STAGES    = 16;
   localparam int OMEGA_W       = 16;
   localparam int ANGLE_W       = 15;

   localparam logic signed [P_W-1:0] ONE_Q14 = 18'sd16384;
   localparam logic [ANGLE_W-1:0]    PI_Q13  = 15'd25736;

   // atan(2^-i) in Q20
   localparam logic [CZ_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
      22'd823550, 22'd486170, 22'd256879, 22'd130396, 22'd65451,
      22'd32757,  22'd16383,  22'd8192,   22'd4096,   22'd2048,
      22'd1024,   22'd512,    22'd256,    22'd128,    22'd64,
      22'd32,     22'd16,     22'd8,      22'd4,      22'd2
   };

   typedef struct packed {
      logic signed [P_W-1:0] px;
      logic signed [P_W-1:0] py;
      logic signed [P_W-1:0] pz;
      logic signed [P_W-1:0] pw;
   } quat_type;

   typedef struct packed {
      logic [2:0]          neg;
      logic                zero;
      logic [ANGLE_W-1:0]  angle;
   } side_type;

   typedef struct packed {
      logic signed [OMEGA_W-1:0] omega_x;
      logic signed [OMEGA_W-1:0] omega_y;
      logic signed [OMEGA_W-1:0] omega_z;
      logic [ANGLE_W-1:0]        angle;
   } result_type;

   function automatic logic signed [P_W-1:0] sx18(input logic [MAT_W-1:0] v);
      return {{(P_W-MAT_W){v[MAT_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rotation_matrix_logarithm_top.sv =====
// Rotation matrix logarithm: Shepperd quaternion, square root, CORDIC atan2, divide
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_m00 .. req_m22 (Q2.14)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_omega_x/y/z, rsp_angle (Q3.13)
//
// One item per cycle while req_stall is low; 4 front stages (branch, canonical sign,
// squares, sum), 31 square-root stages, 20 CORDIC stages, 2 scaling stages,
// 16 divider stages and the output register.
// Synchronous reset clears the valid bits of every stage and the output side.
// A skid register behind the output register takes one item while rsp is stalled;
// req_stall is that skid register's valid bit, so it has no combinational path from rsp_stall.
`default_nettype none
`include "rotation_matrix_logarithm_top_macros.svh"
module rotation_matrix_logarithm_top import rml_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [MAT_W-1:0]   req_m00,
   input  logic signed [MAT_W-1:0]   req_m01,
   input  logic signed [MAT_W-1:0]   req_m02,
   input  logic signed [MAT_W-1:0]   req_m10,
   input  logic signed [MAT_W-1:0]   req_m11,
   input  logic signed [MAT_W-1:0]   req_m12,
   input  logic signed [MAT_W-1:0]   req_m20,
   input  logic signed [MAT_W-1:0]   req_m21,
   input  logic signed [MAT_W-1:0]   req_m22,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OMEGA_W-1:0] rsp_omega_x,
   output logic signed [OMEGA_W-1:0] rsp_omega_y,
   output logic signed [OMEGA_W-1:0] rsp_omega_z,
   output logic [ANGLE_W-1:0]        rsp_angle
);

   logic pipe_en;

   // front stages
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   quat_type          s1_quat_ff, s1_quat_in;
   quat_type          s2_quat_ff, s2_quat_in;
   quat_type          s3_quat_ff, s4_quat_ff;
   logic [SQ_W-1:0]   s3_sq_ff [3];
   logic [SQ_W-1:0]   s3_sq_in [3];
   logic [SUMSQ_W-1:0] s4_sum_ff;

   // square root
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   quat_type          sq_quat;

   // CORDIC
   logic [CORDIC_STAGES-1:0] cv_ff, cv_in;
   logic signed [CX_W-1:0]   cx_ff [CORDIC_STAGES];
   logic signed [CX_W-1:0]   cx_in [CORDIC_STAGES];
   logic signed [CX_W-1:0]   cy_ff [CORDIC_STAGES];
   logic signed [CX_W-1:0]   cy_in [CORDIC_STAGES];
   logic signed [CZ_W-1:0]   cz_ff [CORDIC_STAGES];
   logic signed [CZ_W-1:0]   cz_in [CORDIC_STAGES];
   quat_type                 cq_ff [CORDIC_STAGES];
   quat_type                 cq_in [CORDIC_STAGES];
   logic [ROOT_W-1:0]        cn_ff [CORDIC_STAGES];
   logic [ROOT_W-1:0]        cn_in [CORDIC_STAGES];

   // scaling
   logic              p1_valid_ff, p2_valid_ff;
   logic [PROD_W-1:0] p1_prod_ff [3];
   logic [PROD_W-1:0] p1_prod_in [3];
   side_type          p1_side_ff, p1_side_in;
   logic [ROOT_W-1:0] p1_n_ff;
   logic [DIVD_W-1:0] p2_dvd_ff [3];
   logic [DIVS_W-1:0] p2_dvs_ff;
   side_type          p2_side_ff;

   // divider sideband
   logic [DIV_STAGES-1:0] dv_ff;
   side_type              ds_ff [DIV_STAGES];
   logic [QUO_W-1:0]      quot [3];
   logic                  sat  [3];

   // output
   result_type fin;
   result_type out_ff, sk_ff;
   logic       out_valid_ff, sk_valid_ff;

   assign pipe_en   = !sk_valid_ff;
   assign req_stall = sk_valid_ff;

   // Shepperd branch selection
   always_comb begin
      logic signed [P_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
      logic signed [P_W-1:0] tr;
      logic signed [P_W-1:0] a;
      e00 = sx18(req_m00); e01 = sx18(req_m01); e02 = sx18(req_m02);
      e10 = sx18(req_m10); e11 = sx18(req_m11); e12 = sx18(req_m12);
      e20 = sx18(req_m20); e21 = sx18(req_m21); e22 = sx18(req_m22);
      tr = e00 + e11 + e22;
      a  = '0;
      if (tr > 0) begin
         s1_quat_in.pw = tr + ONE_Q14;
         s1_quat_in.px = e21 - e12;
         s1_quat_in.py = e02 - e20;
         s1_quat_in.pz = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         a = ONE_Q14 + e00 - e11 - e22;
         s1_quat_in.px = (a < 0) ? '0 : a;
         s1_quat_in.pw = e21 - e12;
         s1_quat_in.py = e01 + e10;
         s1_quat_in.pz = e02 + e20;
      end else if (e11 > e22) begin
         a = ONE_Q14 + e11 - e00 - e22;
         s1_quat_in.py = (a < 0) ? '0 : a;
         s1_quat_in.pw = e02 - e20;
         s1_quat_in.px = e01 + e10;
         s1_quat_in.pz = e12 + e21;
      end else begin
         a = ONE_Q14 + e22 - e00 - e11;
         s1_quat_in.pz = (a < 0) ? '0 : a;
         s1_quat_in.pw = e10 - e01;
         s1_quat_in.px = e02 + e20;
         s1_quat_in.py = e12 + e21;
      end
   end

   // flip to non-negative scalar part
   always_comb begin
      if (s1_quat_ff.pw < 0) begin
         s2_quat_in.px = -s1_quat_ff.px;
         s2_quat_in.py = -s1_quat_ff.py;
         s2_quat_in.pz = -s1_quat_ff.pz;
         s2_quat_in.pw = -s1_quat_ff.pw;
      end else begin
         s2_quat_in = s1_quat_ff;
      end
   end

   always_comb begin
      logic signed [2*P_W-1:0] sx, sy, sz;
      sx = s2_quat_ff.px * s2_quat_ff.px;
      sy = s2_quat_ff.py * s2_quat_ff.py;
      sz = s2_quat_ff.pz * s2_quat_ff.pz;
      s3_sq_in[0] = sx[SQ_W-1:0];
      s3_sq_in[1] = sy[SQ_W-1:0];
      s3_sq_in[2] = sz[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_quat_ff <= s1_quat_in;
         s2_quat_ff <= s2_quat_in;
         s3_quat_ff <= s2_quat_ff;
         s3_sq_ff   <= s3_sq_in;
         s4_quat_ff <= s3_quat_ff;
         s4_sum_ff  <= SUMSQ_W'(s3_sq_ff[0]) + SUMSQ_W'(s3_sq_ff[1])
                       + SUMSQ_W'(s3_sq_ff[2]);
      end
   end

   rml_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (s4_valid_ff),
      .in_radicand (s4_sum_ff),
      .in_quat     (s4_quat_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_quat    (sq_quat)
   );

   // vectoring CORDIC: z converges to atan2(|v|, w)
   always_comb begin
      logic signed [CX_W-1:0] xp, yp, xs, ys;
      logic signed [CZ_W-1:0] zp, at;
      logic                   vp;
      quat_type               qp;
      logic [ROOT_W-1:0]      np;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (k == 0) begin
            xp = CX_W'(sq_quat.pw) <<< 24;
            yp = signed'(CX_W'(sq_root) << 11);
            zp = '0;
            vp = sq_valid;
            qp = sq_quat;
            np = sq_root;
         end else begin
            xp = cx_ff[k-1];
            yp = cy_ff[k-1];
            zp = cz_ff[k-1];
            vp = cv_ff[k-1];
            qp = cq_ff[k-1];
            np = cn_ff[k-1];
         end
         xs = xp >>> k;
         ys = yp >>> k;
         at = signed'(ATAN_TAB[k]);
         if (yp > 0) begin
            cx_in[k] = xp + ys;
            cy_in[k] = yp - xs;
            cz_in[k] = zp + at;
         end else if (yp < 0) begin
            cx_in[k] = xp - ys;
            cy_in[k] = yp + xs;
            cz_in[k] = zp - at;
         end else begin
            cx_in[k] = xp;
            cy_in[k] = yp;
            cz_in[k] = zp;
         end
         cv_in[k] = vp;
         cq_in[k] = qp;
         cn_in[k] = np;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (pipe_en) begin
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         cq_ff <= cq_in;
         cn_ff <= cn_in;
      end
   end

   // angle and |p_j| * z
   always_comb begin
      logic signed [CZ_W-1:0] zl;
      logic [ZC_W-1:0]        zc;
      logic [ZC_W+1:0]        ang;
      quat_type               ql;
      logic signed [P_W-1:0]  pj [3];
      logic [P_W-1:0]         mg;
      zl = cz_ff[CORDIC_STAGES-1];
      ql = cq_ff[CORDIC_STAGES-1];
      // drop a small negative residual
      zc = (zl < 0) ? '0 : zl[ZC_W-1:0];
      ang = ({1'b0, zc, 1'b0} + (ZC_W+2)'(64)) >> 7;
      p1_side_in.angle = (ang > (ZC_W+2)'(PI_Q13)) ? PI_Q13 : ang[ANGLE_W-1:0];
      p1_side_in.zero  = (cn_ff[CORDIC_STAGES-1] == '0);
      pj[0] = ql.px;
      pj[1] = ql.py;
      pj[2] = ql.pz;
      for (int j = 0; j < 3; j++) begin
         mg = (pj[j] < 0) ? P_W'(-pj[j]) : P_W'(pj[j]);
         p1_side_in.neg[j] = pj[j] < 0;
         p1_prod_in[j] = PROD_W'(mg[MAG_W-1:0]) * PROD_W'(zc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p1_valid_ff <= cv_ff[CORDIC_STAGES-1];
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // dividend 2*|p|*z*128 + n over divisor 2n rounds half away from zero
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_prod_ff <= p1_prod_in;
         p1_side_ff <= p1_side_in;
         p1_n_ff    <= cn_ff[CORDIC_STAGES-1];
         for (int j = 0; j < 3; j++) begin
            p2_dvd_ff[j] <= DIVD_W'({p1_prod_ff[j], 8'b0}) + DIVD_W'(p1_n_ff);
         end
         p2_dvs_ff  <= {p1_n_ff, 1'b0};
         p2_side_ff <= p1_side_ff;
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      rml_divq u_divq (
         .clock       (clock),
         .en          (pipe_en),
         .in_dividend (p2_dvd_ff[j]),
         .in_divisor  (p2_dvs_ff),
         .out_quot    (quot[j]),
         .out_sat     (sat[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (pipe_en) begin
         dv_ff <= {dv_ff[DIV_STAGES-2:0], p2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ds_ff[0] <= p2_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   // sign, saturation and the zero-rotation case
   always_comb begin
      logic [ANGLE_W-1:0]        mg;
      logic signed [OMEGA_W-1:0] om [3];
      side_type                  sd;
      sd = ds_ff[DIV_STAGES-1];
      for (int j = 0; j < 3; j++) begin
         if (sat[j] || quot[j] > QUO_W'(PI_Q13)) begin
            mg = PI_Q13;
         end else begin
            mg = quot[j][ANGLE_W-1:0];
         end
         if (sd.zero) begin
            om[j] = '0;
         end else if (sd.neg[j]) begin
            om[j] = -signed'({1'b0, mg});
         end else begin
            om[j] = signed'({1'b0, mg});
         end
      end
      fin.omega_x = om[0];
      fin.omega_y = om[1];
      fin.omega_z = om[2];
      fin.angle   = sd.zero ? '0 : sd.angle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else if (out_valid_ff && rsp_stall) begin
         // hold the output, park the arriving item
         if (pipe_en && dv_ff[DIV_STAGES-1]) begin
            sk_valid_ff <= 1'b1;
         end
      end else if (sk_valid_ff) begin
         out_valid_ff <= 1'b1;
         sk_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_stall) begin
         if (pipe_en) begin
            sk_ff <= fin;
         end
      end else if (sk_valid_ff) begin
         out_ff <= sk_ff;
      end else begin
         out_ff <= fin;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_omega_x = out_ff.omega_x;
   assign rsp_omega_y = out_ff.omega_y;
   assign rsp_omega_z = out_ff.omega_z;
   assign rsp_angle   = out_ff.angle;

   `RML_ASSERT_IMPL(a_skid_behind_out, clock, reset, sk_valid_ff, out_valid_ff)
   `RML_ASSERT_NEXT(a_last_holds, clock, reset, sk_valid_ff && dv_ff[DIV_STAGES-1], dv_ff[DIV_STAGES-1])
   `RML_ASSERT_IMPL(a_angle_range, clock, reset, rsp_valid, rsp_angle <= PI_Q13)
   `RML_ASSERT_IMPL(a_omega_x_range, clock, reset, rsp_valid, rsp_omega_x >= -16'sd25736 && rsp_omega_x <= 16'sd25736)

endmodule
`default_nettype wire

// ===== rtl/rml_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with quaternion sideband
`default_nettype none
module rml_isqrt import rml_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SUMSQ_W-1:0]  in_radicand,
   input  quat_type            in_quat,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output quat_type            out_quat
);

   logic [SQ_STAGES-1:0] valid_ff, valid_in;
   logic [REM_W-1:0]     rem_ff  [SQ_STAGES];
   logic [REM_W-1:0]     rem_in  [SQ_STAGES];
   logic [ROOT_W-1:0]    root_ff [SQ_STAGES];
   logic [ROOT_W-1:0]    root_in [SQ_STAGES];
   logic [SUMSQ_W-1:0]   rad_ff  [SQ_STAGES];
   logic [SUMSQ_W-1:0]   rad_in  [SQ_STAGES];
   quat_type             quat_ff [SQ_STAGES];
   quat_type             quat_in [SQ_STAGES];

   always_comb begin
      logic [REM_W-1:0]   rem_p;
      logic [REM_W-1:0]   rem_t;
      logic [REM_W-1:0]   trial;
      logic [ROOT_W-1:0]  root_p;
      logic [SUMSQ_W-1:0] rad_p;
      logic               vp;
      quat_type           qp;
      for (int k = 0; k < SQ_STAGES; k++) begin
         if (k == 0) begin
            rem_p  = '0;
            root_p = '0;
            rad_p  = in_radicand;
            vp     = in_valid;
            qp     = in_quat;
         end else begin
            rem_p  = rem_ff[k-1];
            root_p = root_ff[k-1];
            rad_p  = rad_ff[k-1];
            vp     = valid_ff[k-1];
            qp     = quat_ff[k-1];
         end
         // bring down the next two radicand bits; the low pairs are zero
         rem_t = {rem_p[REM_W-3:0], rad_p[SUMSQ_W-1 -: 2]};
         trial = {{(REM_W-ROOT_W-2){1'b0}}, root_p, 2'b01};
         if (rem_t >= trial) begin
            rem_in[k]  = rem_t - trial;
            root_in[k] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_t;
            root_in[k] = {root_p[ROOT_W-2:0], 1'b0};
         end
         rad_in[k]   = {rad_p[SUMSQ_W-3:0], 2'b00};
         valid_in[k] = vp;
         quat_in[k]  = qp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         quat_ff <= quat_in;
      end
   end

   assign out_valid = valid_ff[SQ_STAGES-1];
   assign out_root  = root_ff[SQ_STAGES-1];
   assign out_quat  = quat_ff[SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/rml_divq.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module rml_divq import rml_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [DIVD_W-1:0]  in_dividend,
   input  logic [DIVS_W-1:0]  in_divisor,
   output logic [QUO_W-1:0]   out_quot,
   output logic               out_sat
);

   logic [REMD_W-1:0] rem_ff  [DIV_STAGES];
   logic [REMD_W-1:0] rem_in  [DIV_STAGES];
   logic [DIVS_W-1:0] dvs_ff  [DIV_STAGES];
   logic [DIVS_W-1:0] dvs_in  [DIV_STAGES];
   logic [QUO_W-1:0]  quot_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quot_in [DIV_STAGES];
   logic              sat_ff  [DIV_STAGES];
   logic              sat_in  [DIV_STAGES];

   always_comb begin
      logic [REMD_W-1:0] rem_p;
      logic [REMD_W-1:0] dsh;
      logic [DIVS_W-1:0] dvs_p;
      logic [QUO_W-1:0]  quot_p;
      logic              sat_p;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            rem_p  = REMD_W'(in_dividend);
            dvs_p  = in_divisor;
            quot_p = '0;
            // quotient would not fit in QUO_W bits
            sat_p  = REMD_W'(in_dividend) >= (REMD_W'(in_divisor) << QUO_W);
         end else begin
            rem_p  = rem_ff[k-1];
            dvs_p  = dvs_ff[k-1];
            quot_p = quot_ff[k-1];
            sat_p  = sat_ff[k-1];
         end
         dsh = REMD_W'(dvs_p) << (QUO_W - 1 - k);
         if (rem_p >= dsh) begin
            rem_in[k]  = rem_p - dsh;
            quot_in[k] = {quot_p[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_p;
            quot_in[k] = {quot_p[QUO_W-2:0], 1'b0};
         end
         dvs_in[k] = dvs_p;
         sat_in[k] = sat_p;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_quot = quot_ff[DIV_STAGES-1];
   assign out_sat  = sat_ff[DIV_STAGES-1];

endmodule
`default_nettype wire
